/* sv/gsl_pkg.sv */
// Shared types, codes and constants of the Gauss-Seidel solver.
package gsl_pkg;

  localparam int MAX_SIZE_DEF = 8;

  localparam logic [3:0]  SIZE_RST  = 4'd8;
  localparam logic [15:0] ITER_RST  = 16'd100;
  localparam logic [31:0] LIMIT_RST = 32'd0;

  localparam logic signed [63:0] NUM_LIM = 64'sd140737488355327;

  typedef enum logic [1:0] {
    FUNC_WR_A  = 2'd0,
    FUNC_WR_B  = 2'd1,
    FUNC_SOLVE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_SIZE  = 2'd0,
    CFG_ITER  = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_ROW_INIT,
    ST_EL_RD,
    ST_EL_MUL,
    ST_EL_ACC,
    ST_ROW_END,
    ST_DIV,
    ST_WRX,
    ST_NEXT_ROW,
    ST_SQ,
    ST_RADD,
    ST_CHECK,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_e;

  typedef struct packed {
    logic solve_init;
    logic sweep_init;
    logic res_init;
    logic row_init;
    logic mul;
    logic acc;
    logic set_derr;
    logic div_start;
    logic div_step;
    logic write_x;
    logic next_i;
    logic sweep_inc;
    logic sq;
    logic radd;
    logic set_conv;
    logic clr_j;
    logic inc_j;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic res_mode;
    logic diag_zero;
    logic div_last;
    logic sweeps_done;
    logic acc_le_lim;
    logic out_pend;
    logic out_last;
  } sts_t;

endpackage

/* sv/gsl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/gsl_datapath.sv */
// Datapath: stores, multiply-accumulate, divider, residual sum, output register.
module gsl_datapath import gsl_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_acc_i,
  input  logic [1:0]         func_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [2:0]         index_o,
  output logic signed [31:0] solution_o,
  output logic               last_o,
  output logic               converged_o,
  output logic               divide_error_o,
  output logic [15:0]        sweeps_used_o
);

  localparam int IW = $clog2(MAX_SIZE);
  localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
  localparam logic [6:0] MaxN = 7'(MAX_SIZE);

  logic [3:0]  size_q;
  logic [15:0] iter_q;
  logic [31:0] limit_q;

  logic [IW-1:0] nm1_q, i_q, j_q;
  logic          res_mode_q;
  logic signed [63:0] sigma_q;
  logic [63:0]   prod_q, acc_q;
  logic          big_q;
  logic [31:0]   diag_q;
  logic [63:0]   dq_q;
  logic [31:0]   rem_q, dvs_q;
  logic [5:0]    dcnt_q;
  logic          neg_q;
  logic [15:0]   sweeps_q;
  logic          conv_q, derr_q;
  logic [MAX_SIZE-1:0] xvalid_q;
  logic          xv_q;

  logic          out_valid_q, last_q, conv_out_q, derr_out_q;
  logic [2:0]    index_q;
  logic [31:0]   sol_q;
  logic [15:0]   sweeps_out_q;

  logic [31:0] a_rd, b_rd, x_rd;
  logic signed [31:0] xd;
  logic        row_ok, col_ok;
  func_e       func;

  assign func   = func_e'(func_i);
  assign row_ok = {4'd0, row_i} < MaxN;
  assign col_ok = {4'd0, col_i} < MaxN;

  function automatic logic [AW-1:0] mat_addr(logic [IW-1:0] r, logic [IW-1:0] c);
    mat_addr = AW'(r) * AW'(MAX_SIZE) + AW'(c);
  endfunction

  logic a_we, b_we;
  assign a_we = in_acc_i && (func == FUNC_WR_A) && row_ok && col_ok;
  assign b_we = in_acc_i && (func == FUNC_WR_B) && row_ok;

  // Solution write value from the divider, saturated to 32 bits.
  logic [31:0] xnew;
  always_comb begin
    logic [63:0] qneg;
    qneg = -dq_q;
    if (!neg_q) begin
      xnew = (dq_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dq_q[31:0];
    end else begin
      xnew = (dq_q > 64'h8000_0000) ? 32'h8000_0000 : qneg[31:0];
    end
  end

  gsl_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (mat_addr(IW'(row_i), IW'(col_i))),
    .wdata_i (value_i),
    .raddr_i (mat_addr(i_q, j_q)),
    .rdata_o (a_rd)
  );

  gsl_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_b_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (IW'(row_i)),
    .wdata_i (value_i),
    .raddr_i (i_q),
    .rdata_o (b_rd)
  );

  gsl_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write_x),
    .waddr_i (i_q),
    .wdata_i (xnew),
    .raddr_i (j_q),
    .rdata_o (x_rd)
  );

  // Entries not written since the solve began read as zero.
  assign xd = xv_q ? $signed(x_rd) : 32'sd0;

  logic signed [63:0] resid, num, numsat;
  logic [63:0]        mag, nmag;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [63:0] term;
  logic [64:0]        acc_sum;
  logic [32:0]        dtrial;
  logic               dge;

  always_comb begin
    resid  = sigma_q - 64'($signed(b_rd));
    mag    = resid[63] ? -resid : resid;
    num    = 64'($signed(b_rd)) - sigma_q;
    numsat = num;
    if (num > NUM_LIM) numsat = NUM_LIM;
    if (num < -NUM_LIM) numsat = -NUM_LIM;
    nmag   = numsat[63] ? -numsat : numsat;
    mul_a  = cmd_i.sq ? $signed({1'b0, mag[31:0]}) : $signed({a_rd[31], a_rd});
    mul_b  = cmd_i.sq ? $signed({1'b0, mag[31:0]}) : $signed({xd[31], xd});
    mul_p  = mul_a * mul_b;
    term   = {{16{prod_q[63]}}, prod_q[63:16]};
    acc_sum = {1'b0, acc_q} + {1'b0, (big_q ? 64'hFFFF_FFFF_FFFF_FFFF : prod_q)};
    dtrial = {rem_q, dq_q[63]};
    dge    = dtrial >= {1'b0, dvs_q};
  end

  // Configuration registers and control-side counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RST;
      iter_q      <= ITER_RST;
      limit_q     <= LIMIT_RST;
      nm1_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      res_mode_q  <= 1'b0;
      dcnt_q      <= '0;
      sweeps_q    <= '0;
      conv_q      <= 1'b0;
      derr_q      <= 1'b0;
      xvalid_q    <= '0;
      xv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SIZE:  size_q  <= cfg_data_i[3:0];
          CFG_ITER:  iter_q  <= cfg_data_i[15:0];
          CFG_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      xv_q <= xvalid_q[j_q];
      if (cmd_i.solve_init) begin
        if (size_q == 4'd0) begin
          nm1_q <= '0;
        end else if ({3'd0, size_q} > MaxN) begin
          nm1_q <= IW'(MaxN - 7'd1);
        end else begin
          nm1_q <= IW'({3'd0, size_q} - 7'd1);
        end
        xvalid_q <= '0;
        sweeps_q <= '0;
        conv_q   <= 1'b0;
        derr_q   <= 1'b0;
      end
      if (cmd_i.sweep_init) begin
        i_q        <= '0;
        res_mode_q <= 1'b0;
      end
      if (cmd_i.res_init) begin
        i_q        <= '0;
        res_mode_q <= 1'b1;
      end
      if (cmd_i.next_i) i_q <= i_q + 1'b1;
      if (cmd_i.row_init || cmd_i.clr_j) j_q <= '0;
      if ((cmd_i.acc && (j_q != nm1_q)) || cmd_i.inc_j) j_q <= j_q + 1'b1;
      if (cmd_i.sweep_inc) sweeps_q <= sweeps_q + 16'd1;
      if (cmd_i.set_derr) derr_q <= 1'b1;
      if (cmd_i.set_conv) conv_q <= 1'b1;
      if (cmd_i.div_start) dcnt_q <= '0;
      if (cmd_i.div_step) dcnt_q <= dcnt_q + 6'd1;
      if (cmd_i.write_x) xvalid_q[i_q] <= 1'b1;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Arithmetic payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_init) sigma_q <= '0;
    if (cmd_i.mul || cmd_i.sq) prod_q <= mul_p[63:0];
    if (cmd_i.mul && (j_q == i_q)) diag_q <= a_rd;
    if (cmd_i.acc && !(!res_mode_q && (j_q == i_q))) sigma_q <= sigma_q + term;
    if (cmd_i.sq) big_q <= |mag[63:32];
    if (cmd_i.res_init) acc_q <= '0;
    if (cmd_i.radd) acc_q <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
    if (cmd_i.div_start) begin
      dq_q  <= nmag << 16;
      rem_q <= '0;
      dvs_q <= diag_q[31] ? -diag_q : diag_q;
      neg_q <= numsat[63] ^ diag_q[31];
    end
    if (cmd_i.div_step) begin
      rem_q <= dge ? 32'(dtrial - {1'b0, dvs_q}) : dtrial[31:0];
      dq_q  <= {dq_q[62:0], dge};
    end
    if (cmd_i.out_load) begin
      index_q      <= 3'(j_q);
      sol_q        <= xd;
      last_q       <= (j_q == nm1_q);
      conv_out_q   <= conv_q;
      derr_out_q   <= derr_q;
      sweeps_out_q <= sweeps_q;
    end
  end

  always_comb begin
    sts_o.j_last      = (j_q == nm1_q);
    sts_o.i_last      = (i_q == nm1_q);
    sts_o.res_mode    = res_mode_q;
    sts_o.diag_zero   = (diag_q == 32'd0);
    sts_o.div_last    = (dcnt_q == 6'd63);
    sts_o.sweeps_done = (sweeps_q == iter_q);
    sts_o.acc_le_lim  = (acc_q <= {32'd0, limit_q});
    sts_o.out_pend    = out_valid_q;
    sts_o.out_last    = last_q;
  end

  assign out_valid_o    = out_valid_q;
  assign index_o        = index_q;
  assign solution_o     = sol_q;
  assign last_o         = last_q;
  assign converged_o    = conv_out_q;
  assign divide_error_o = derr_out_q;
  assign sweeps_used_o  = sweeps_out_q;

endmodule

/* sv/gsl_ctrl.sv */
// Controller: sequences loads, sweeps, residual passes and result transfer.
module gsl_ctrl import gsl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] func_i,
  output logic       in_stall_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (func_e'(func_i) == FUNC_SOLVE)) begin
          cmd_o.solve_init = 1'b1;
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.sweeps_done) begin
          cmd_o.clr_j = 1'b1;
          state_d = ST_OUT_RD;
        end else begin
          cmd_o.sweep_init = 1'b1;
          state_d = ST_ROW_INIT;
        end
      end
      ST_ROW_INIT: begin
        cmd_o.row_init = 1'b1;
        state_d = ST_EL_RD;
      end
      ST_EL_RD: state_d = ST_EL_MUL;
      ST_EL_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_EL_ACC;
      end
      ST_EL_ACC: begin
        cmd_o.acc = 1'b1;
        if (!sts_i.j_last) begin
          state_d = ST_EL_RD;
        end else if (sts_i.res_mode) begin
          state_d = ST_SQ;
        end else begin
          state_d = ST_ROW_END;
        end
      end
      ST_ROW_END: begin
        // Skip the update of a row whose diagonal is zero.
        if (sts_i.diag_zero) begin
          cmd_o.set_derr = 1'b1;
          state_d = ST_NEXT_ROW;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_WRX;
      end
      ST_WRX: begin
        cmd_o.write_x = 1'b1;
        state_d = ST_NEXT_ROW;
      end
      ST_NEXT_ROW: begin
        if (sts_i.i_last) begin
          cmd_o.sweep_inc = 1'b1;
          cmd_o.res_init  = 1'b1;
        end else begin
          cmd_o.next_i = 1'b1;
        end
        state_d = ST_ROW_INIT;
      end
      ST_SQ: begin
        cmd_o.sq = 1'b1;
        state_d = ST_RADD;
      end
      ST_RADD: begin
        cmd_o.radd = 1'b1;
        if (sts_i.i_last) begin
          state_d = ST_CHECK;
        end else begin
          cmd_o.next_i = 1'b1;
          state_d = ST_ROW_INIT;
        end
      end
      ST_CHECK: begin
        if (sts_i.acc_le_lim) begin
          cmd_o.set_conv = 1'b1;
          cmd_o.clr_j    = 1'b1;
          state_d = ST_OUT_RD;
        end else if (sts_i.sweeps_done) begin
          cmd_o.clr_j = 1'b1;
          state_d = ST_OUT_RD;
        end else begin
          cmd_o.sweep_init = 1'b1;
          state_d = ST_ROW_INIT;
        end
      end
      ST_OUT_RD: state_d = ST_OUT_LD;
      ST_OUT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        // Advance once the pending transaction has gone out.
        if (!sts_i.out_pend) begin
          if (sts_i.out_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.inc_j = 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* sv/gauss_seidel_linear_solver.sv */
// A write transaction stores one matrix or right-hand element. A solve with n unknowns runs
// sweeps of row sums plus a 64-step divider (skipped for a row with a zero diagonal), each
// followed by a residual pass; the n results then go out one at a time, held by output stall.
// One item is worked on at a time; the input stalls until the last result is taken.
// Reset (asynchronous, active low) clears control state and restores the config
// registers; matrix and right-hand stores stay undefined until written.
module gauss_seidel_linear_solver import gsl_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         index_o,
  output logic signed [31:0] solution_o,
  output logic               last_o,
  output logic               converged_o,
  output logic               divide_error_o,
  output logic [15:0]        sweeps_used_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;

  gsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gsl_datapath #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_acc_i       (in_acc),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .value_i        (value_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .index_o        (index_o),
    .solution_o     (solution_o),
    .last_o         (last_o),
    .converged_o    (converged_o),
    .divide_error_o (divide_error_o),
    .sweeps_used_o  (sweeps_used_o)
  );

endmodule

/* sv/gsl_checker.sv */
// Port-level checker for the solver and its bind statement.
module gsl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] solution_o,
  input logic               converged_o,
  input logic [15:0]        sweeps_used_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(solution_o))
    else $error("stalled result changed");

  // Input is taken only when no result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input open while result pending");

  // Results are spaced: a taken transaction is never followed at once by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("back-to-back results");

  // Convergence needs at least one sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |-> sweeps_used_o != 16'd0)
    else $error("converged with no sweeps");

endmodule

bind gauss_seidel_linear_solver gsl_checker u_gsl_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench of the Gauss-Seidel solver with a fixed-point predictor.
`timescale 1ns / 100ps

module tb_top;
  import gsl_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;

  typedef struct {
    logic [2:0]  index;
    logic [31:0] solution;
    logic        last;
    logic        converged;
    logic        divide_error;
    logic [15:0] sweeps;
  } sol_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i = FUNC_WR_A;
  logic [2:0]         row_i = '0;
  logic [2:0]         col_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         index_o;
  logic signed [31:0] solution_o;
  logic               last_o;
  logic               converged_o;
  logic               divide_error_o;
  logic [15:0]        sweeps_used_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_SIZE;
  logic [31:0]        cfg_data_i = '0;

  // predictor state
  logic signed [31:0] a_mat [8][8];
  logic signed [31:0] b_vec [8];
  logic signed [31:0] x_vec [8];
  logic [3:0]         size_reg  = SIZE_RST;
  logic [15:0]        iter_reg  = ITER_RST;
  logic [31:0]        limit_reg = LIMIT_RST;

  sol_t sol_q[$];
  int   errors   = 0;
  int   sent     = 0;
  int   hold_cnt = 0;
  bit   idle_on  = 1'b1;

  gauss_seidel_linear_solver DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint row_sum(int i, int n, int skip);
    longint s;
    s = 0;
    for (int j = 0; j < n; j++)
      if (j != skip) s += (longint'(a_mat[i][j]) * longint'(x_vec[j])) >>> 16;
    return s;
  endfunction

  function automatic longint unsigned residual(int n);
    longint unsigned acc, m, sq;
    longint r;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      r = row_sum(i, n, n) - longint'(b_vec[i]);
      m = (r < 0) ? -r : r;
      sq = (m >= 64'h1_0000_0000) ? ~64'd0 : m * m;
      acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
    end
    return acc;
  endfunction

  function automatic void solve_predict();
    int n;
    longint num, q;
    int unsigned sweeps;
    bit conv, derr;
    sol_t s;
    n = (size_reg == 0) ? 1 : (size_reg > 8) ? 8 : size_reg;
    sweeps = 0; conv = 0; derr = 0;
    for (int i = 0; i < 8; i++) x_vec[i] = '0;
    while (sweeps < iter_reg) begin
      for (int i = 0; i < n; i++) begin
        if (a_mat[i][i] == 0) begin
          derr = 1;
        end else begin
          num = longint'(b_vec[i]) - row_sum(i, n, i);
          if (num > NUM_LIM) num = NUM_LIM;
          if (num < -NUM_LIM) num = -NUM_LIM;
          q = (num * 65536) / longint'(a_mat[i][i]);
          if (q > 64'sd2147483647) q = 64'sd2147483647;
          if (q < -64'sd2147483648) q = -64'sd2147483648;
          x_vec[i] = q[31:0];
        end
      end
      sweeps++;
      if (residual(n) <= {32'd0, limit_reg}) begin
        conv = 1;
        break;
      end
    end
    for (int k = 0; k < n; k++) begin
      s.index = k[2:0];
      s.solution = x_vec[k];
      s.last = (k == n - 1);
      s.converged = conv;
      s.divide_error = derr;
      s.sweeps = sweeps[15:0];
      sol_q.push_back(s);
    end
  endfunction

  // offer one transaction, hold it until accepted, then update the predictor
  task automatic send_item(logic [1:0] f, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    if (idle_on && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 36) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f; row_i <= r; col_i <= c; value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
    case (f)
      FUNC_WR_A:  a_mat[r][c] = v;
      FUNC_WR_B:  b_vec[r] = v;
      FUNC_SOLVE: solve_predict();
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sol_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_cfg(cfg_idx_e idx, logic [31:0] d);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SIZE:  size_reg = d[3:0];
      CFG_ITER:  iter_reg = d[15:0];
      CFG_LIMIT: limit_reg = d;
      default: ;
    endcase
  endtask

  task automatic solve_with(logic [31:0] sz, logic [31:0] it, logic [31:0] lim);
    set_cfg(CFG_SIZE, sz);
    set_cfg(CFG_ITER, it);
    set_cfg(CFG_LIMIT, lim);
    send_item(FUNC_SOLVE, 3'($urandom), 3'($urandom), $urandom);
  endtask

  function automatic logic [31:0] diag_val();
    logic [31:0] d;
    d = 32'h4_0000 + $urandom_range(0, 32'h4_0000);
    return $urandom_range(1) ? d : -d;
  endfunction

  function automatic logic [31:0] small_val(int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // receiver: random stall, or a counted hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      out_stall_i <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 36);
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    sol_t s;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sol_q.size() == 0) begin
        $error("result transaction with nothing expected: index %0d", index_o);
        errors++;
      end else begin
        s = sol_q.pop_front();
        check_field("index", s.index, index_o);
        check_field("solution", s.solution, solution_o);
        check_field("last", s.last, last_o);
        check_field("converged", s.converged, converged_o);
        check_field("divide_error", s.divide_error, divide_error_o);
        check_field("sweeps_used", s.sweeps, sweeps_used_o);
      end
    end
  end

  // define every store entry so no solve reads an unwritten one
  task automatic test_load();
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++)
        send_item(FUNC_WR_A, 3'(i), 3'(j), (i == j) ? diag_val() : small_val(32'h8000));
      send_item(FUNC_WR_B, 3'(i), 3'd0, small_val(32'h10_0000));
    end
  endtask

  task automatic test_reset_config();
    send_item(FUNC_SOLVE, 0, 0, 0);
  endtask

  task automatic test_extremes();
    send_item(FUNC_WR_A, 0, 0, 32'h0001_0000);
    send_item(FUNC_WR_B, 0, 0, 32'h7FFF_FFFF);
    solve_with(1, 2, 0);
    send_item(FUNC_WR_B, 0, 0, 32'h8000_0000);
    send_item(FUNC_SOLVE, 7, 7, 32'hFFFF_FFFF);
    send_item(FUNC_WR_A, 0, 0, 32'h0000_0001);
    send_item(FUNC_SOLVE, 0, 0, 0);
    send_item(FUNC_WR_A, 0, 0, 32'h8000_0000);
    send_item(FUNC_WR_B, 0, 0, 32'h7FFF_FFFF);
    send_item(FUNC_SOLVE, 0, 0, 0);
  endtask

  task automatic test_zero_diag();
    send_item(FUNC_WR_A, 1, 1, 32'h0);
    solve_with(2, 3, 32'hFFFF_FFFF);
    send_item(FUNC_WR_A, 1, 1, diag_val());
  endtask

  task automatic test_no_iter();
    solve_with(3, 0, 32'hFFFF_FFFF);
  endtask

  task automatic test_size_clamp();
    solve_with(0, 1, 0);
    solve_with(15, 1, 0);
  endtask

  task automatic test_long_limit();
    send_item(FUNC_WR_A, 0, 0, 32'h0001_0000);
    send_item(FUNC_WR_B, 0, 0, 32'h0003_8000);
    solve_with(1, 65535, 32'hFFFF_FFFF);
    solve_with(1, 65535, 0);
  endtask

  task automatic test_ignored();
    send_item(FUNC_NONE, 3'h7, 3'h7, 32'hFFFF_FFFF);
    send_item(FUNC_NONE, 0, 0, 0);
    send_item(FUNC_SOLVE, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    set_cfg(CFG_SIZE, 2);
    set_cfg(CFG_ITER, 1);
    wait_drained();
    hold_cnt = 1500;
    for (int k = 0; k < 4; k++) begin
      send_item(FUNC_WR_B, 3'(k[0]), 0, small_val(32'h1_0000));
      send_item(FUNC_SOLVE, 0, 0, 0);
    end
  endtask

  task automatic test_random();
    int n;
    while (sent < 280) begin
      idle_on = !(sent > 200 && sent < 250);
      n = $urandom_range(1, 8);
      if ($urandom_range(99) < 70) begin
        // diagonally dominant system, usually converges
        for (int i = 0; i < n; i++) begin
          send_item(FUNC_WR_A, 3'(i), 3'(i), diag_val());
          send_item(FUNC_WR_A, 3'(i), 3'($urandom_range(7)), small_val(32'h8000));
          send_item(FUNC_WR_B, 3'(i), 3'($urandom), small_val(32'h10_0000));
        end
        solve_with(n, $urandom_range(1, 10),
                   $urandom_range(3) == 0 ? 32'h0 : $urandom_range(32'h100, 32'hFFFF_FFFF));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(9))
            0:       send_item(FUNC_NONE, 3'($urandom), 3'($urandom), $urandom);
            1, 2:    send_item(FUNC_WR_B, 3'($urandom), 3'($urandom), $urandom);
            default: send_item(FUNC_WR_A, 3'($urandom), 3'($urandom), $urandom);
          endcase
        end
        case ($urandom_range(5))
          0:       solve_with(0, $urandom_range(1, 4), $urandom);
          1:       solve_with($urandom_range(9, 15), $urandom_range(1, 3), $urandom);
          default: solve_with(n, $urandom_range(1, 6), $urandom);
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load();
    test_reset_config();
    test_extremes();
    test_zero_diag();
    test_no_iter();
    test_size_clamp();
    test_long_limit();
    test_ignored();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && sol_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
sv/gsl_pkg.sv
sv/gsl_ram.sv
sv/gsl_datapath.sv
sv/gsl_ctrl.sv
sv/gauss_seidel_linear_solver.sv
sv/gsl_checker.sv
dv/tb_top.sv
